// ===== rtl/tfc_pkg.sv =====
package tfc_pkg;

  // Field widths
  localparam int unsigned WORD_W    = 64;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned IDX_W     = 13;
  localparam int unsigned TLEN_W    = 12;
  localparam int unsigned STATUS_W  = 2;

  // Frame constants
  localparam logic [7:0] HEADER_ID_VALUE   = 8'hAA;
  localparam logic [7:0] FOOTER_ID_VALUE   = 8'h55;
  localparam logic [1:0] STATE_BOTH        = 2'b11;  // info bits 7..6 both set
  localparam logic [1:0] STATE_BUFFER_FULL = 2'b10;  // info bits 7..6 = buffer full
  localparam int unsigned CONTINUE_BIT     = 4;

  // Reset values of the configuration registers
  localparam logic [CFG_W-1:0] RISE_RESET = 16'd32;
  localparam logic [CFG_W-1:0] FALL_RESET = 16'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FALL = 2'd1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FAIL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LAST = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // Everything the back end needs from one frame
  typedef struct packed {
    logic [TLEN_W-1:0] trig_len;
    logic [7:0]        info;
    logic              hdr_ok;
    logic              rise_ok;
    logic              fall_ok;
    logic [23:0]       charge;
    logic [23:0]       stamp;
    logic              foot_ok;
    logic [31:0]       obj_id;
  } frame_rec_t;

  typedef struct packed {
    logic       valid;
    frame_rec_t rec;
  } rec_beat_t;

endpackage

// ===== rtl/tfc_front.sv =====
module tfc_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tfc_pkg::WORD_W-1:0]     frame_word,
  input  logic                           cfg_wr_en,
  input  logic [tfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfc_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           q_full,
  output tfc_pkg::rec_beat_t             push
);
  import tfc_pkg::*;

  logic [IDX_W-1:0]  word_index;
  logic [CFG_W-1:0]  rise_thr;
  logic [CFG_W-1:0]  fall_thr;
  frame_rec_t        cur;
  logic              accept;
  logic              is_last;
  logic              is_footer;
  logic [IDX_W-1:0]  len_ext;

  assign len_ext   = {1'b0, cur.trig_len};
  assign is_footer = (word_index == len_ext + IDX_W'(2));
  assign is_last   = (word_index == len_ext + IDX_W'(3));
  // Only the closing word needs a queue slot.
  assign in_stall  = is_last && q_full;
  assign accept    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
      rise_thr   <= RISE_RESET;
      fall_thr   <= FALL_RESET;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == REG_RISE) rise_thr <= cfg_data;
        if (cfg_index == REG_FALL) fall_thr <= cfg_data;
      end
      if (accept) begin
        word_index <= is_last ? '0 : word_index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (accept) begin
      if (word_index == IDX_W'(0)) begin
        cur.stamp    <= frame_word[23:0];
        cur.info     <= frame_word[31:24];
        cur.trig_len <= frame_word[43:32];
        cur.hdr_ok   <= (frame_word[63:56] == HEADER_ID_VALUE);
      end else if (word_index == IDX_W'(1)) begin
        cur.fall_ok  <= (frame_word[15:0] == fall_thr);
        cur.rise_ok  <= (frame_word[31:16] == rise_thr);
        cur.charge   <= frame_word[55:32];
      end
      if (is_footer) begin
        cur.obj_id  <= frame_word[31:0];
        cur.foot_ok <= (frame_word[63:56] == FOOTER_ID_VALUE);
      end
    end
  end

  assign push.valid = accept && is_last;
  assign push.rec   = cur;

endmodule

// ===== rtl/tfc_queue.sv =====
module tfc_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  tfc_pkg::rec_beat_t push,
  output logic               full,
  output tfc_pkg::rec_beat_t head,
  input  logic               pop
);
  import tfc_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  frame_rec_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign do_push = push.valid && !full;
  assign do_pop  = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) count <= count + CNT_W'(1);
      else if (do_pop && !do_push) count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push.rec;
  end

  assign head.valid = (count != '0);
  assign head.rec   = entries[rd_ptr];

endmodule

// ===== rtl/tfc_back.sv =====
module tfc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  tfc_pkg::rec_beat_t            head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tfc_pkg::STATUS_W-1:0]  check_status,
  output logic [12:0]                   frame_length,
  output logic [7:0]                    trigger_flags,
  output logic signed [23:0]            charge_sum,
  output logic [23:0]                   header_timestamp,
  output logic [31:0]                   footer_obj_id
);
  import tfc_pkg::*;

  logic [STATUS_W-1:0] status;
  frame_rec_t          r;

  assign r = head.rec;

  // Later rules override earlier ones.
  always_comb begin
    status = ST_OK;
    if (r.obj_id == '0) begin
      if (r.info[7:6] == STATE_BOTH) status = ST_FAIL;
      else if (!r.info[CONTINUE_BIT]) status = ST_LAST;
    end else if (!r.info[CONTINUE_BIT]) begin
      status = ST_LAST;
    end
    if (r.info[7:6] == STATE_BUFFER_FULL) status = ST_FULL;
    if (!r.hdr_ok || !r.rise_ok || !r.fall_ok) status = ST_FAIL;
    if (!r.foot_ok) status = ST_FAIL;
  end

  assign pop = head.valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      check_status     <= status;
      frame_length     <= {1'b0, r.trig_len} + 13'd4;
      trigger_flags    <= r.info;
      charge_sum       <= r.charge;
      header_timestamp <= r.stamp;
      footer_obj_id    <= r.obj_id;
    end
  end

endmodule

// ===== rtl/trigger_frame_checker.sv =====
// Trigger frame checker.
//
// Input channel: one 64-bit frame word per beat on frame_word, qualified by
// in_valid and held off by in_stall. Word 0 is the header, word 1 carries the
// charge sum and thresholds, word length+2 is the footer, and the frame ends
// at word length+3. Output channel: one status beat per frame, qualified by
// out_valid and held off by out_stall, carrying the status code and the
// decoded header, charge and footer fields.
//
// Throughput: one word per clock while in_stall is low, set by the single
// word counter in the front end. Result path: the status beat enters the
// queue as the last word of its frame is taken and is then loaded into the
// output register, from which the receiver takes it. The front end keeps
// taking words while results wait; in_stall rises only on a closing word
// when the queue of QUEUE_DEPTH finished frames is full, which needs the
// receiver to stall for several frames in a row.
//
// Reset (rst, synchronous) empties the queue and the output register, returns
// the word counter to the header and loads the thresholds with 32 and 0.
// Write thresholds through cfg_wr_en/cfg_index/cfg_data only while idle;
// word 1 is compared with the values in force when it arrives.
module trigger_frame_checker #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tfc_pkg::WORD_W-1:0]    frame_word,
  input  logic                          cfg_wr_en,
  input  logic [tfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tfc_pkg::CFG_W-1:0]     cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tfc_pkg::STATUS_W-1:0]  check_status,
  output logic [12:0]                   frame_length,
  output logic [7:0]                    trigger_flags,
  output logic signed [23:0]            charge_sum,
  output logic [23:0]                   header_timestamp,
  output logic [31:0]                   footer_obj_id
);
  import tfc_pkg::*;

  rec_beat_t push;
  rec_beat_t head;
  logic      q_full;
  logic      pop;

  // Front end: count words, capture header, word 1 and footer fields.
  tfc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .frame_word (frame_word),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push)
  );

  // Hold finished frames so the front end keeps running while output stalls.
  tfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (q_full),
    .head (head),
    .pop  (pop)
  );

  // Back end: resolve status priority and drive the output register.
  tfc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .check_status     (check_status),
    .frame_length     (frame_length),
    .trigger_flags    (trigger_flags),
    .charge_sum       (charge_sum),
    .header_timestamp (header_timestamp),
    .footer_obj_id    (footer_obj_id)
  );

endmodule

// ===== rtl/tfc_checker.sv =====
module tfc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tfc_pkg::STATUS_W-1:0]  check_status,
  input logic [12:0]                   frame_length,
  input logic [7:0]                    trigger_flags,
  input logic signed [23:0]            charge_sum,
  input logic [23:0]                   header_timestamp,
  input logic [31:0]                   footer_obj_id
);
  import tfc_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(check_status) &&
      $stable(frame_length) && $stable(trigger_flags) && $stable(charge_sum) &&
      $stable(header_timestamp) && $stable(footer_obj_id))
    else $error("stalled result beat changed");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result beat present after reset");

  // Frame length covers header, word 1, footer and last word.
  a_len_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> frame_length >= 13'd4 && frame_length <= 13'd4099)
    else $error("frame length out of range");

  // Buffer full and last frame follow the trigger state bits.
  a_full_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && check_status == ST_FULL |-> trigger_flags[7:6] == STATE_BUFFER_FULL)
    else $error("buffer full without buffer full state");

  a_ok_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (check_status == ST_OK || check_status == ST_LAST) |->
      trigger_flags[7:6] != STATE_BUFFER_FULL &&
      (trigger_flags[CONTINUE_BIT] == (check_status == ST_OK)))
    else $error("ok or last frame status disagrees with trigger info");

endmodule

bind trigger_frame_checker tfc_checker u_tfc_checker (.*);
